FILE: rtl/core/stok_pkg.sv
// Shared types, character codes and keyword tables for the script tokenizer.
// No dependencies; used by stok_lexer, stok_fifo and script_tokenizer_unit.
package stok_pkg;

    localparam int KW_COUNT = 15;
    localparam int KW_MAXLEN = 15;

    // Token kinds as carried on the result tuser
    typedef enum logic [2:0] {
        KIND_TEXT  = 3'd0,
        KIND_IDENT = 3'd1,
        KIND_KEYWD = 3'd2,
        KIND_INT   = 3'd3,
        KIND_DEC   = 3'd4,
        KIND_STR   = 3'd5,
        KIND_OTHER = 3'd6,
        KIND_END   = 3'd7
    } kind_t;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_N   = 8'h6E;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;

    // Keyword text, right-aligned: the last character sits in the low byte
    localparam logic [8*KW_MAXLEN-1:0] KW_TEXT [KW_COUNT] = '{
        120'("if"), 120'("while"), 120'("wait"), 120'("set"), 120'("stop"),
        120'("movej"), 120'("movel"), 120'("speedj"), 120'("speedl"),
        120'("stopj"), 120'("stopl"), 120'({"teach", "_mode"}),
        120'({"end_teach", "_mode"}), 120'("MoveCamera"),
        120'({"set_digital", "_out"})
    };

    localparam logic [4:0] KW_LEN [KW_COUNT] = '{
        5'd2, 5'd5, 5'd4, 5'd3, 5'd4, 5'd5, 5'd5, 5'd6,
        5'd6, 5'd5, 5'd5, 5'd10, 5'd14, 5'd10, 5'd15
    };

    // Result payload, first field in the high bits
    typedef struct packed {
        logic [7:0]  text_char;
        logic        fraction_truncated;
        logic [3:0]  fraction_digits;
        logic [29:0] fraction_value;
        logic [31:0] magnitude;
        logic        negative;
        logic [3:0]  keyword_index;
    } tok_data_t;

    typedef struct packed {
        kind_t     kind;
        tok_data_t data;
        logic      last;
    } tok_result_t;

    // Write strobes from the lexer into the result queue
    typedef struct packed {
        logic first;
        logic second;
    } push_t;

    // Keywords that still match when character c sits at position pos
    function automatic logic [KW_COUNT-1:0] kw_keep(logic [4:0] pos, logic [7:0] c);
        logic [KW_COUNT-1:0] keep;
        keep = '0;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            if (pos < KW_LEN[k])
            begin
                keep[k] = (KW_TEXT[k][8*(int'(KW_LEN[k]) - 1 - int'(pos)) +: 8] == c);
            end
        end
        return keep;
    endfunction

    // Lowest keyword still in the mask whose length equals the identifier length
    function automatic logic [4:0] kw_find(logic [KW_COUNT-1:0] mask, logic [4:0] pos);
        logic [4:0] hit;
        hit = '0;
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            if (mask[k] && (KW_LEN[k] == pos))
            begin
                hit = {1'b1, 4'(k)};
            end
        end
        return hit;
    endfunction

endpackage

FILE: rtl/core/stok_lexer.sv
// Lexer state and single-pass next-state logic of the script tokenizer.
// Depends on stok_pkg; produces up to two results per accepted word.
module stok_lexer #(
    parameter int MAX_FRACTION_DIGITS = 9
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic                  end_cmd,
    input  logic [7:0]            char_code,
    output stok_pkg::push_t       push,
    output stok_pkg::tok_result_t res0,
    output stok_pkg::tok_result_t res1
);

    localparam int FCW = $clog2(MAX_FRACTION_DIGITS + 1);
    localparam logic [FCW-1:0] FRAC_MAX = FCW'(MAX_FRACTION_DIGITS);

    typedef enum logic [2:0] {
        M_IDLE, M_HASH, M_BSLASH, M_IDENT, M_INT, M_FRAC, M_STR
    } mode_t;

    mode_t                          mode_reg, mode_next;
    logic [stok_pkg::KW_COUNT-1:0]  mask_reg, mask_next;
    logic [4:0]                     pos_reg, pos_next;
    logic                           neg_reg, neg_next;
    logic [31:0]                    mag_reg, mag_next;
    logic [29:0]                    acc_reg, acc_next;
    logic [FCW-1:0]                 cnt_reg, cnt_next;
    logic                           ovf_reg, ovf_next;

    logic        is_alpha, is_digit;
    logic [7:0]  dval;
    logic [4:0]  kw_hit;

    stok_pkg::tok_result_t fin_r, st_r, a_r, b_r;
    logic        fin_v, st_v, a_v, b_v;
    mode_t       st_mode;
    logic [stok_pkg::KW_COUNT-1:0] st_mask;
    logic [4:0]  st_pos;
    logic        st_neg;
    logic [31:0] st_mag;
    logic        take_fin, take_start, do_clear;

    assign is_alpha = ((char_code >= stok_pkg::CH_LO_A) && (char_code <= stok_pkg::CH_LO_Z))
                   || ((char_code >= stok_pkg::CH_UP_A) && (char_code <= stok_pkg::CH_UP_Z));
    assign is_digit = (char_code >= stok_pkg::CH_ZERO) && (char_code <= stok_pkg::CH_NINE);
    assign dval     = char_code - stok_pkg::CH_ZERO;
    assign kw_hit   = stok_pkg::kw_find(mask_reg, pos_reg);

    // Token closed from the current state
    always_comb
    begin
        fin_r = '0;
        fin_v = 1'b0;
        case (mode_reg)
            M_BSLASH:
            begin
                fin_v = 1'b1;
                fin_r.kind = stok_pkg::KIND_OTHER;
                fin_r.data.text_char = stok_pkg::CH_BSLASH;
            end
            M_IDENT:
            begin
                fin_v = 1'b1;
                if (kw_hit[4])
                begin
                    fin_r.kind = stok_pkg::KIND_KEYWD;
                    fin_r.data.keyword_index = kw_hit[3:0];
                end
                else
                begin
                    fin_r.kind = stok_pkg::KIND_IDENT;
                end
            end
            M_INT:
            begin
                fin_v = 1'b1;
                fin_r.kind = stok_pkg::KIND_INT;
                fin_r.data.negative = neg_reg;
                fin_r.data.magnitude = mag_reg;
            end
            M_FRAC:
            begin
                fin_v = 1'b1;
                fin_r.kind = stok_pkg::KIND_DEC;
                fin_r.data.negative = neg_reg;
                fin_r.data.magnitude = mag_reg;
                fin_r.data.fraction_value = acc_reg;
                fin_r.data.fraction_digits = 4'(cnt_reg);
                fin_r.data.fraction_truncated = ovf_reg;
            end
            M_STR:
            begin
                fin_v = 1'b1;
                fin_r.kind = stok_pkg::KIND_STR;
            end
            default:
            begin
                fin_v = 1'b0;
            end
        endcase
    end

    // Token opened by the current character from a cleared state
    always_comb
    begin
        st_r    = '0;
        st_v    = 1'b0;
        st_mode = M_IDLE;
        st_mask = '1;
        st_pos  = '0;
        st_neg  = 1'b0;
        st_mag  = '0;
        if (char_code == stok_pkg::CH_SPACE)
        begin
            st_mode = M_IDLE;
        end
        else if (char_code == stok_pkg::CH_HASH)
        begin
            st_mode = M_HASH;
        end
        else if (char_code == stok_pkg::CH_BSLASH)
        begin
            st_mode = M_BSLASH;
        end
        else if (is_alpha)
        begin
            st_mode = M_IDENT;
            st_mask = stok_pkg::kw_keep(5'd0, char_code);
            st_pos  = 5'd1;
            st_v    = 1'b1;
            st_r.kind = stok_pkg::KIND_TEXT;
            st_r.data.text_char = char_code;
        end
        else if (is_digit)
        begin
            st_mode = M_INT;
            st_mag  = {24'd0, dval};
        end
        else if (char_code == stok_pkg::CH_MINUS)
        begin
            st_mode = M_INT;
            st_neg  = 1'b1;
        end
        else if (char_code == stok_pkg::CH_QUOTE)
        begin
            st_mode = M_STR;
        end
        else
        begin
            st_v = 1'b1;
            st_r.kind = stok_pkg::KIND_OTHER;
            st_r.data.text_char = char_code;
        end
    end

    // Next state and the up to two results of this word
    always_comb
    begin
        mode_next  = mode_reg;
        mask_next  = mask_reg;
        pos_next   = pos_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        take_fin   = 1'b0;
        take_start = 1'b0;
        do_clear   = 1'b0;
        b_v        = 1'b0;
        b_r        = '0;

        if (fire)
        begin
            if (end_cmd)
            begin
                take_fin = 1'b1;
                do_clear = 1'b1;
                b_v = 1'b1;
                b_r.kind = stok_pkg::KIND_END;
            end
            else
            begin
                case (mode_reg)
                    M_HASH:
                    begin
                        take_start = !is_alpha;
                    end
                    M_BSLASH:
                    begin
                        if (char_code == stok_pkg::CH_LO_N)
                        begin
                            do_clear = 1'b1;
                        end
                        else
                        begin
                            take_fin   = 1'b1;
                            take_start = 1'b1;
                        end
                    end
                    M_IDENT:
                    begin
                        if (is_alpha || is_digit || (char_code == stok_pkg::CH_UNDER))
                        begin
                            mask_next = mask_reg & stok_pkg::kw_keep(pos_reg, char_code);
                            if (pos_reg != 5'd31)
                            begin
                                pos_next = pos_reg + 5'd1;
                            end
                            b_v = 1'b1;
                            b_r.kind = stok_pkg::KIND_TEXT;
                            b_r.data.text_char = char_code;
                        end
                        else
                        begin
                            take_fin   = 1'b1;
                            take_start = 1'b1;
                        end
                    end
                    M_INT:
                    begin
                        if (is_digit)
                        begin
                            mag_next = mag_reg * 32'd10 + {24'd0, dval};
                        end
                        else if (char_code == stok_pkg::CH_DOT)
                        begin
                            mode_next = M_FRAC;
                        end
                        else
                        begin
                            take_fin   = 1'b1;
                            take_start = 1'b1;
                        end
                    end
                    M_FRAC:
                    begin
                        if (is_digit)
                        begin
                            if (cnt_reg < FRAC_MAX)
                            begin
                                acc_next = acc_reg * 30'd10 + {22'd0, dval};
                                cnt_next = cnt_reg + FCW'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        else
                        begin
                            take_fin   = 1'b1;
                            take_start = 1'b1;
                        end
                    end
                    M_STR:
                    begin
                        if (char_code == stok_pkg::CH_QUOTE)
                        begin
                            take_fin = 1'b1;
                            do_clear = 1'b1;
                        end
                        else
                        begin
                            b_v = 1'b1;
                            b_r.kind = stok_pkg::KIND_TEXT;
                            b_r.data.text_char = char_code;
                        end
                    end
                    default:
                    begin
                        take_start = 1'b1;
                    end
                endcase
            end

            if (do_clear || take_start)
            begin
                mode_next = M_IDLE;
                mask_next = '1;
                pos_next  = '0;
                neg_next  = 1'b0;
                mag_next  = '0;
                acc_next  = '0;
                cnt_next  = '0;
                ovf_next  = 1'b0;
            end
            if (take_start)
            begin
                mode_next = st_mode;
                mask_next = st_mask;
                pos_next  = st_pos;
                neg_next  = st_neg;
                mag_next  = st_mag;
                b_v = st_v;
                b_r = st_r;
            end
        end
    end

    assign a_v = take_fin && fin_v;
    assign a_r = fin_r;

    // Order the results: closed token first, then the word's own result
    always_comb
    begin
        res0 = a_v ? a_r : b_r;
        res1 = b_r;
        res0.last = !(a_v && b_v);
        res1.last = 1'b1;
        push.first  = a_v || b_v;
        push.second = a_v && b_v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            mask_reg <= '1;
            pos_reg  <= '0;
            neg_reg  <= 1'b0;
            mag_reg  <= '0;
            acc_reg  <= '0;
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            mask_reg <= mask_next;
            pos_reg  <= pos_next;
            neg_reg  <= neg_next;
            mag_reg  <= mag_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            ovf_reg  <= ovf_next;
        end
    end

endmodule

FILE: rtl/core/stok_fifo.sv
// Four-entry result queue of the script tokenizer: two writes, one read per cycle.
// Depends on stok_pkg for the result and push types.
module stok_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  stok_pkg::push_t       push,
    input  stok_pkg::tok_result_t wr0,
    input  stok_pkg::tok_result_t wr1,
    input  logic                  pop_ready,
    output logic                  out_valid,
    output stok_pkg::tok_result_t out_head,
    output logic                  room
);

    localparam int DEPTH = 4;
    localparam int PW = $clog2(DEPTH);

    stok_pkg::tok_result_t mem_reg [DEPTH];
    logic [PW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [PW:0]   cnt_reg, cnt_next;
    logic          pop;

    assign out_valid = (cnt_reg != '0);
    assign out_head  = mem_reg[rd_reg];
    assign pop       = out_valid && pop_ready;
    // Room for a word that may bring two results
    assign room      = (cnt_reg <= (PW+1)'(DEPTH - 2));

    always_comb
    begin
        wr_next  = wr_reg + PW'(push.first) + PW'(push.second);
        rd_next  = rd_reg + PW'(pop);
        cnt_next = cnt_reg + (PW+1)'(push.first) + (PW+1)'(push.second) - (PW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.first)
        begin
            mem_reg[wr_reg] <= wr0;
        end
        if (push.second)
        begin
            mem_reg[wr_reg + PW'(1)] <= wr1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: rtl/core/script_tokenizer_unit.sv
// Top level of the script tokenizer: lexer plus result queue.
// Depends on stok_pkg, stok_lexer and stok_fifo.
//
// Usage:
//   Slave side takes one word per script character: s_tdata is the character
//   byte, s_tuser is the command (0 = character, 1 = end of script).
//   Master side gives token results: m_tuser is the token kind, m_tdata the
//   token fields, m_tlast marks the last result caused by one input word.
//   Identifier and string text streams out as one text-char result per
//   character; the identifier, keyword or string result follows when the
//   token closes. The end-of-script word closes any open token first.
// Results: each is registered into the queue and shown from the queue head.
// Throughput: one word per cycle while the receiver takes one result per
//   cycle; a word that closes a token and opens another gives two results.
// Stall: results wait in the queue; s_tready drops while fewer than two
//   entries are free and rises again as the receiver drains the queue.
// Reset: the lexer returns to idle with a full keyword mask and cleared
//   number accumulators, and the queue empties.
module script_tokenizer_unit #(
    parameter int MAX_FRACTION_DIGITS = 9
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic [0:0]  s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] keyword_index, [4] negative, [36:5] magnitude,
    // [66:37] fraction_value, [70:67] fraction_digits,
    // [71] fraction_truncated, [79:72] text_char
    output logic [79:0] m_tdata,
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast
);

    stok_pkg::push_t       push;
    stok_pkg::tok_result_t res0, res1, head;
    logic                  fire, room;

    // Accept a word only when the queue can hold both of its results
    assign s_tready = room;
    assign fire     = s_tvalid && room;

    stok_lexer #(
        .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
    ) u_lexer (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .end_cmd   (s_tuser[0]),
        .char_code (s_tdata),
        .push      (push),
        .res0      (res0),
        .res1      (res1)
    );

    stok_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr0       (res0),
        .wr1       (res1),
        .pop_ready (m_tready),
        .out_valid (m_tvalid),
        .out_head  (head),
        .room      (room)
    );

    // Drive the master side straight from the queue head
    assign m_tdata = head.data;
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule
